// ===== rtl/lrt_pkg.sv =====
// shared types, constants and elaboration-time tables for the layer relight tone mapper
`timescale 1ns / 1ps
package lrt_pkg;

   localparam int SUM_W       = 24;
   localparam int EXP_STEPS   = 24;
   localparam int LIN_ENTRY_W = 25;
   localparam int Q_DEPTH     = 2;
   localparam int CSR_IDX_W   = 2;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [63:0] EXP22_Q24 = 64'd36909875;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_EXP      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPOSURE_LEVEL = CSR_IDX_W'(1);

   localparam logic [15:0] GAMMA_RESET = 16'd9011;
   localparam logic [15:0] LEVEL_RESET = 16'd4096;
   localparam logic [15:0] SAT_ONE     = 16'h8000;

   typedef logic [EXP_STEPS-1:0][31:0] expk_type;
   typedef logic [255:0][LIN_ENTRY_W-1:0] lin_tab_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_m;
      v = v_in;
      res = '0;
      bit_m = 64'd1 << 62;
      while (bit_m > v) bit_m = bit_m >> 2;
      while (bit_m != 64'd0) begin
         if (v >= res + bit_m) begin
            v = v - (res + bit_m);
            res = (res >> 1) + bit_m;
         end else begin
            res = res >> 1;
         end
         bit_m = bit_m >> 2;
      end
      return res;
   endfunction

   // 2^-(2^-(k+1)) in q.32 at index k, each one the square root of the one before
   function automatic expk_type build_exp_k();
      expk_type t;
      logic [63:0] k;
      k = isqrt64(64'd1 << 63);
      t[0] = k[31:0];
      for (int i = 1; i < EXP_STEPS; i++) begin
         k = isqrt64(k << 32);
         t[i] = k[31:0];
      end
      return t;
   endfunction

   localparam expk_type EXP_K = build_exp_k();

   function automatic logic [63:0] neg_log2_c(input logic [63:0] v, input int f);
      int p;
      logic [63:0] m;
      logic [63:0] frac;
      p = 0;
      while (p < 63 && (v >> (p + 1)) != 64'd0) p++;
      m = (p <= 31) ? (v << (31 - p)) : (v >> (p - 31));
      frac = '0;
      for (int i = 0; i < EXP_STEPS; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(f - p) << 24) - frac;
   endfunction

   function automatic logic [63:0] exp2_neg_c(input logic [63:0] e);
      logic [63:0] n;
      logic [63:0] acc;
      n = e >> 24;
      acc = 64'd1 << 32;
      for (int k = 0; k < EXP_STEPS; k++) begin
         if (e[23-k]) acc = (acc * 64'(EXP_K[k])) >> 32;
      end
      if (n >= 64'd64) return 64'd0;
      return acc >> n;
   endfunction

   // linearizing table, (i/255)^2.2 with lfb fraction bits
   function automatic lin_tab_type build_lin(input int lfb);
      lin_tab_type t;
      logic [63:0] v;
      logic [63:0] e;
      logic [63:0] y;
      t[0] = '0;
      t[255] = LIN_ENTRY_W'(1) << lfb;
      for (int i = 1; i < 255; i++) begin
         v = (64'(i) << 32) / 64'd255;
         e = (neg_log2_c(v, 32) * EXP22_Q24) >> 24;
         y = exp2_neg_c(e);
         y = (y + (64'd1 << (31 - lfb))) >> (32 - lfb);
         t[i] = y[LIN_ENTRY_W-1:0];
      end
      return t;
   endfunction

endpackage

// ===== rtl/lrt_ifs.sv =====
// channel interfaces: layer input, pixel result and register write
`timescale 1ns / 1ps
interface lrt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [15:0] hue;
   logic [15:0] sat;
   logic [15:0] val;
   logic       last_layer;
   modport source(output valid, red, green, blue, hue, sat, val, last_layer, input ready);
   modport sink(input valid, red, green, blue, hue, sat, val, last_layer, output ready);
endinterface

interface lrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   modport source(output valid, out_red, out_green, out_blue, input ready);
   modport sink(input valid, out_red, out_green, out_blue, output ready);
endinterface

interface lrt_csr_if import lrt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// ===== rtl/lrt_front.sv =====
// front end: tint, linearize, multiply and accumulate layers into per-pixel sums
`timescale 1ns / 1ps
module lrt_front import lrt_pkg::*; #(
   parameter int MAX_LAYERS       = 16,
   parameter int LINEAR_FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   lrt_req_if.sink    req,
   input  q_stat_type q_stat,
   output logic       push,
   output sums_type   push_data
);

   localparam int LW = LINEAR_FRAC_BITS + 1;
   localparam int PW = LW + 1;
   localparam int AW = ((PW > SUM_W) ? PW : SUM_W) + 1;
   localparam int CW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam lin_tab_type LIN = build_lin(LINEAR_FRAC_BITS);

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [PW-1:0] b);
      logic [AW-1:0] s;
      s = AW'(a) + AW'(b);
      return (s > AW'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   logic advance, accept, term;

   // stage 1
   logic          p1_valid_ff, p1_valid_in;
   logic [LW-1:0] p1_lr_ff, p1_lg_ff, p1_lb_ff;
   logic [2:0]    p1_sector_ff;
   logic [16:0]   p1_t_ff, t_in;
   logic [15:0]   p1_c_ff, p1_val_ff;
   logic          p1_last_ff;
   logic [18:0]   h6;
   logic [15:0]   sat_c;
   logic [31:0]   cprod;

   // stage 2
   logic          p2_valid_ff;
   logic [LW-1:0] p2_lr_ff, p2_lg_ff, p2_lb_ff;
   logic [2:0]    p2_sector_ff;
   logic [15:0]   p2_c_ff, p2_x_ff, p2_m_ff;
   logic          p2_last_ff;
   logic [32:0]   xp1;
   logic [15:0]   xprod_s2;

   // stage 3
   logic          p3_valid_ff;
   logic [PW-1:0] p3_pr_ff, p3_pg_ff, p3_pb_ff;
   logic          p3_last_ff;
   logic [15:0]   tr, tg, tb;
   logic [LW+15:0] prod_r, prod_g, prod_b;

   sums_type      sums_ff, sums_in, sums_next;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign term      = p3_last_ff || (cnt_ff == CW'(MAX_LAYERS - 1));
   assign advance   = !(p3_valid_ff && term && q_stat.full);
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   assign h6     = 19'(req.hue) * 19'd6;
   assign sat_c  = (req.sat > SAT_ONE) ? SAT_ONE : req.sat;
   assign cprod  = 32'(req.val) * 32'(sat_c);
   assign t_in   = h6[16] ? (17'd65536 - 17'(h6[15:0])) : 17'(h6[15:0]);
   assign p1_valid_in = accept;

   assign xp1      = 33'(p1_c_ff) * 33'(p1_t_ff);
   assign xprod_s2 = xp1[31:16];

   // hsv sector decode
   always_comb begin
      unique case (p2_sector_ff)
         3'd0:    begin tr = p2_c_ff; tg = p2_x_ff; tb = '0;      end
         3'd1:    begin tr = p2_x_ff; tg = p2_c_ff; tb = '0;      end
         3'd2:    begin tr = '0;      tg = p2_c_ff; tb = p2_x_ff; end
         3'd3:    begin tr = '0;      tg = p2_x_ff; tb = p2_c_ff; end
         3'd4:    begin tr = p2_x_ff; tg = '0;      tb = p2_c_ff; end
         default: begin tr = p2_c_ff; tg = '0;      tb = p2_x_ff; end
      endcase
   end

   assign prod_r = (LW+16)'(p2_lr_ff) * (LW+16)'(tr + p2_m_ff);
   assign prod_g = (LW+16)'(p2_lg_ff) * (LW+16)'(tg + p2_m_ff);
   assign prod_b = (LW+16)'(p2_lb_ff) * (LW+16)'(tb + p2_m_ff);

   assign sums_next.red   = sat_add(sums_ff.red, p3_pr_ff);
   assign sums_next.green = sat_add(sums_ff.green, p3_pg_ff);
   assign sums_next.blue  = sat_add(sums_ff.blue, p3_pb_ff);

   assign push      = p3_valid_ff && term && !q_stat.full;
   assign push_data = sums_next;

   always_comb begin
      sums_in = sums_ff;
      cnt_in  = cnt_ff;
      if (p3_valid_ff && advance) begin
         if (term) begin
            sums_in = '0;
            cnt_in  = '0;
         end else begin
            sums_in = sums_next;
            cnt_in  = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         sums_ff     <= '0;
         cnt_ff      <= '0;
      end else begin
         sums_ff <= sums_in;
         cnt_ff  <= cnt_in;
         if (advance) begin
            p1_valid_ff <= p1_valid_in;
            p2_valid_ff <= p1_valid_ff;
            p3_valid_ff <= p2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_lr_ff     <= LIN[req.red][LW-1:0];
         p1_lg_ff     <= LIN[req.green][LW-1:0];
         p1_lb_ff     <= LIN[req.blue][LW-1:0];
         p1_sector_ff <= h6[18:16];
         p1_t_ff      <= t_in;
         p1_c_ff      <= cprod[30:15];
         p1_val_ff    <= req.val;
         p1_last_ff   <= req.last_layer;

         p2_lr_ff     <= p1_lr_ff;
         p2_lg_ff     <= p1_lg_ff;
         p2_lb_ff     <= p1_lb_ff;
         p2_sector_ff <= p1_sector_ff;
         p2_c_ff      <= p1_c_ff;
         p2_x_ff      <= xprod_s2;
         p2_m_ff      <= p1_val_ff - p1_c_ff;
         p2_last_ff   <= p1_last_ff;

         p3_pr_ff     <= prod_r[LW+15:15];
         p3_pg_ff     <= prod_g[LW+15:15];
         p3_pb_ff     <= prod_b[LW+15:15];
         p3_last_ff   <= p2_last_ff;
      end
   end

endmodule

// ===== rtl/lrt_queue.sv =====
// two-word queue of finished pixel sums between front and back
`timescale 1ns / 1ps
module lrt_queue import lrt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sums_type   push_data,
   input  logic       pop,
   output sums_type   rd_data,
   output q_stat_type q_stat
);

   localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

   sums_type       mem_ff [Q_DEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   count_ff;

   assign rd_data      = mem_ff[rd_ff];
   assign q_stat.full  = (count_ff == (QAW+1)'(Q_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == QAW'(Q_DEPTH - 1)) ? '0 : wr_ff + QAW'(1);
         if (pop)  rd_ff <= (rd_ff == QAW'(Q_DEPTH - 1)) ? '0 : rd_ff + QAW'(1);
         if (push && !pop) count_ff <= count_ff + (QAW+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (QAW+1)'(1);
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("queue push while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("queue pop while empty");
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(Q_DEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/lrt_tone.sv =====
// back end: per-channel tone map through an iterative log2 / exp2 unit
`timescale 1ns / 1ps
module lrt_tone import lrt_pkg::*; #(
   parameter int LINEAR_FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  sums_type   q_data,
   output logic       pop,
   input  logic [15:0] gamma_exp,
   input  logic [15:0] exposure_level,
   lrt_rsp_if.source  rsp
);

   localparam int XW  = LINEAR_FRAC_BITS + 12;
   localparam int XPW = SUM_W + 16;
   localparam int NW  = XW + 32;
   localparam int NCW = $clog2(XW + 1);
   localparam int DW  = NCW + 24;
   localparam int EDW = DW + 16;
   localparam int NNW = EDW - 36;
   localparam logic [4:0] LAST_STEP = 5'(EXP_STEPS - 1);
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_LOAD  = 10'b0000000010,
      ST_CHECK = 10'b0000000100,
      ST_NORM  = 10'b0000001000,
      ST_LOG   = 10'b0000010000,
      ST_SCALE = 10'b0000100000,
      ST_EXP   = 10'b0001000000,
      ST_SHIFT = 10'b0010000000,
      ST_STORE = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [1:0]      ch_ff, ch_in;
   sums_type        sums_ff, sums_in;
   logic [XPW-1:0]  x_ff, x_in;
   logic [NW-1:0]   nrm_ff, nrm_in;
   logic [NCW-1:0]  cnt_ff, cnt_in;
   logic [31:0]     m_ff, m_in;
   logic [23:0]     frac_ff, frac_in;
   logic [4:0]      step_ff, step_in;
   logic [NNW-1:0]  n_ff, n_in;
   logic [23:0]     eb_ff, eb_in;
   logic [32:0]     acc_ff, acc_in;
   logic [32:0]     y_ff, y_in;
   logic [2:0][7:0] res_ff, res_in;
   logic [2:0][7:0] out_ff, out_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [SUM_W-1:0] chan_sum;
   logic [63:0]      sq;
   logic [32:0]      sq_top;
   logic [DW-1:0]    d;
   logic [EDW-1:0]   ed;
   logic [64:0]      am;
   logic [40:0]      yp;
   logic             res_wr;
   logic [7:0]       res_val;

   always_comb begin
      case (ch_ff)
         CH_RED:   chan_sum = sums_ff.red;
         CH_GREEN: chan_sum = sums_ff.green;
         default:  chan_sum = sums_ff.blue;
      endcase
   end

   assign sq     = 64'(m_ff) * 64'(m_ff);
   assign sq_top = sq[63:31];
   assign d      = ((DW'(cnt_ff) + DW'(1)) << 24) - DW'(frac_ff);
   assign ed     = EDW'(d) * EDW'(gamma_exp);
   assign am     = 65'(acc_ff) * 65'(EXP_K[step_ff]);
   assign yp     = 41'(y_ff) * 41'(8'd255);

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_red   = out_ff[CH_RED];
   assign rsp.out_green = out_ff[CH_GREEN];
   assign rsp.out_blue  = out_ff[CH_BLUE];

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      sums_in  = sums_ff;
      x_in     = x_ff;
      nrm_in   = nrm_ff;
      cnt_in   = cnt_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      eb_in    = eb_ff;
      acc_in   = acc_ff;
      y_in     = y_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pop      = 1'b0;
      res_wr   = 1'b0;
      res_val  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               sums_in  = q_data;
               ch_in    = CH_RED;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            x_in     = XPW'(chan_sum) * XPW'(exposure_level);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // zero exponent, no light and light at or above one are settled here
            if (gamma_exp == '0) begin
               res_wr  = 1'b1;
               res_val = 8'd255;
            end else if (x_ff == '0) begin
               res_wr  = 1'b1;
               res_val = 8'd0;
            end else if (x_ff[XPW-1:XW] != '0) begin
               res_wr  = 1'b1;
               res_val = 8'd255;
            end else begin
               nrm_in   = {x_ff[XW-1:0], 32'd0};
               cnt_in   = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (nrm_ff[NW-1]) begin
               m_in     = nrm_ff[NW-1 -: 32];
               frac_in  = '0;
               step_in  = '0;
               state_in = ST_LOG;
            end else begin
               nrm_in = nrm_ff << 1;
               cnt_in = cnt_ff + NCW'(1);
            end
         end
         ST_LOG: begin
            m_in    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            frac_in = {frac_ff[22:0], sq_top[32]};
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            n_in     = ed[EDW-1:36];
            eb_in    = ed[35:12];
            acc_in   = 33'h1_0000_0000;
            step_in  = '0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            if (eb_ff[23]) acc_in = am[64:32];
            eb_in   = eb_ff << 1;
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            y_in     = (n_ff >= NNW'(64)) ? '0 : (acc_ff >> n_ff);
            state_in = ST_STORE;
         end
         ST_STORE: begin
            res_wr  = 1'b1;
            res_val = (yp[40:32] > 9'd255) ? 8'd255 : yp[39:32];
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (res_wr) begin
         res_in[ch_ff] = res_val;
         if (ch_ff == CH_BLUE) begin
            state_in = ST_DONE;
         end else begin
            ch_in    = ch_ff + 2'd1;
            state_in = ST_LOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      sums_ff <= sums_in;
      x_ff    <= x_in;
      nrm_ff  <= nrm_in;
      cnt_ff  <= cnt_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
      n_ff    <= n_in;
      eb_ff   <= eb_in;
      acc_ff  <= acc_in;
      y_ff    <= y_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

endmodule

// ===== rtl/layer_relight_tonemap.sv =====
// top level of the layer relight tone mapper: registers, front, queue and back
`timescale 1ns / 1ps
// Takes one layer word per clock: gamma-encoded rgb of one light layer plus that layer's
// hsv tint. The front linearizes through a 256-entry table, tints, multiplies and adds
// into saturating 24-bit sums in a three-stage pipeline, so layers stream in at one word
// per cycle. When a pixel closes (last_layer, or MAX_LAYERS layers without it) its sums
// go into a two-word queue, and the front only stalls when that queue is full. The back
// tone maps one pixel at a time, channel after channel, on one shared log2/exp2 unit:
// per channel an all-dark, all-bright or zero-exponent case is settled in the load and
// check states; otherwise the channel is normalized, one shift per leading zero of
// sum*exposure_level (up to LINEAR_FRAC_BITS+11), then runs the 24 squaring steps of the
// log and 24 multiply steps of the exponential. A pixel may also wait on the result
// register. With the full log/exp path this takes longer than a pixel of MAX_LAYERS
// layers takes to stream in, so the back end then sets the pixel rate. Registers: index 0
// gamma_exp (q4.12, reset 2.2), index 1 exposure_level (q4.12, reset 1.0); write them
// only while the block is idle.
module layer_relight_tonemap import lrt_pkg::*; #(
   parameter int MAX_LAYERS       = 16,
   parameter int LINEAR_FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   lrt_req_if.sink   req_ch,
   lrt_rsp_if.source rsp_ch,
   lrt_csr_if.sink   csr_ch
);

   // config registers
   logic [15:0] gamma_ff, gamma_in;
   logic [15:0] level_ff, level_in;

   // front to queue to back
   logic       push, pop;
   sums_type   push_data, q_data;
   q_stat_type q_stat;

   // register port never stalls
   assign csr_ch.ready = 1'b1;

   always_comb begin
      gamma_in = gamma_ff;
      level_in = level_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_GAMMA_EXP:      gamma_in = csr_ch.wdata;
            CSR_EXPOSURE_LEVEL: level_in = csr_ch.wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
         level_ff <= LEVEL_RESET;
      end else begin
         gamma_ff <= gamma_in;
         level_ff <= level_in;
      end
   end

   // layer accumulation pipeline
   lrt_front #(
      .MAX_LAYERS      (MAX_LAYERS),
      .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_stat   (q_stat),
      .push     (push),
      .push_data(push_data)
   );

   // pixel sums waiting for tone map
   lrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .rd_data  (q_data),
      .q_stat   (q_stat)
   );

   // tone map sequencer with result register
   lrt_tone #(
      .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
   ) u_tone (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_data        (q_data),
      .pop           (pop),
      .gamma_exp     (gamma_ff),
      .exposure_level(level_ff),
      .rsp           (rsp_ch)
   );

endmodule
